@@ src/fhan_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register codes of the tracking differentiator.
package fhan_pkg;

	localparam int unsigned WIDE_W = 128;
	localparam int unsigned OPB_W  = 64;
	localparam int unsigned CNT_W  = 7;

	localparam logic [1:0] REG_TRACK_SPEED    = 2'd0;
	localparam logic [1:0] REG_STEP_PERIOD    = 2'd1;
	localparam logic [1:0] REG_FILTER_FACTOR  = 2'd2;
	localparam logic [1:0] REG_VELOCITY_LIMIT = 2'd3;

	localparam logic [46:0] TRACK_SPEED_RST    = 47'd1677721600;
	localparam logic [31:0] STEP_PERIOD_RST    = 32'd4294967;
	localparam logic [15:0] FILTER_FACTOR_RST  = 16'd256;
	localparam logic [46:0] VELOCITY_LIMIT_RST = 47'd0;

	localparam logic [15:0] FILTER_FACTOR_MIN = 16'd256;
	localparam logic [60:0] LIN_CAP           = 61'h1 << 60;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [WIDE_W-1:0] a;
		logic [OPB_W-1:0]  b;
		logic [CNT_W-1:0]  steps;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WIDE_W-1:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic [46:0] r;
		logic [31:0] h;
		logic [15:0] n;
		logic [46:0] lim;
	} cfg_t;

	typedef struct packed {
		logic        idle;
		logic        valid;
		logic [47:0] position;
		logic [47:0] velocity;
	} seq_status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RH,
		ST_NH,
		ST_D0,
		ST_HX2,
		ST_BR,
		ST_LIN,
		ST_DD,
		ST_RY,
		ST_SQ,
		ST_A,
		ST_FH,
		ST_RAM,
		ST_LQ,
		ST_HFH,
		ST_HX1,
		ST_DONE
	} seq_state_t;

endpackage

@@ src/fhan_alu.sv @@
`timescale 1ns / 1ps
// Shared bit-serial unit: shift-add multiply, restoring divide and square root.
module fhan_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  fhan_pkg::alu_req_t req,
	output fhan_pkg::alu_rsp_t rsp
);

	logic [fhan_pkg::WIDE_W-1:0] acc_q;
	logic [fhan_pkg::WIDE_W-1:0] sh_q;
	logic [fhan_pkg::WIDE_W-1:0] res_q;
	logic [fhan_pkg::OPB_W-1:0]  mb_q;
	logic [fhan_pkg::CNT_W-1:0]  cnt_q;
	fhan_pkg::alu_op_t           op_q;
	logic                        busy_q;
	logic                        done_q;

	logic [fhan_pkg::WIDE_W-1:0] opnd;
	logic                        sub;
	logic [fhan_pkg::WIDE_W:0]   sum;
	logic                        fits;
	logic [7:0]                  sq_shift;

	// One adder serves all three operations; for subtraction the carry out
	// is high when no borrow occurs.
	always_comb begin
		sub  = (op_q != fhan_pkg::ALU_MUL);
		opnd = (op_q == fhan_pkg::ALU_SQRT) ? (res_q | sh_q) : sh_q;
		sum  = {1'b0, acc_q} + {1'b0, (sub ? ~opnd : opnd)}
			+ {{fhan_pkg::WIDE_W{1'b0}}, sub};
		fits = sum[fhan_pkg::WIDE_W];
		sq_shift = {req.steps, 1'b0} - 8'd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= fhan_pkg::ALU_MUL;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
			op_q   <= req.op;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == {{(fhan_pkg::CNT_W-1){1'b0}}, 1'b1}) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			res_q <= '0;
			mb_q  <= req.b;
			case (req.op)
				fhan_pkg::ALU_MUL: begin
					acc_q <= '0;
					sh_q  <= req.a;
				end
				fhan_pkg::ALU_DIV: begin
					acc_q <= req.a;
					sh_q  <= {{(fhan_pkg::WIDE_W-fhan_pkg::OPB_W){1'b0}}, req.b}
						<< (req.steps - 1'b1);
				end
				fhan_pkg::ALU_SQRT: begin
					acc_q <= req.a;
					sh_q  <= {{(fhan_pkg::WIDE_W-1){1'b0}}, 1'b1} << sq_shift;
				end
				default: begin
					acc_q <= req.a;
					sh_q  <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				fhan_pkg::ALU_MUL: begin
					if (mb_q[0]) begin
						acc_q <= sum[fhan_pkg::WIDE_W-1:0];
					end
					sh_q <= sh_q << 1;
					mb_q <= mb_q >> 1;
				end
				fhan_pkg::ALU_DIV: begin
					if (fits) begin
						acc_q <= sum[fhan_pkg::WIDE_W-1:0];
					end
					res_q <= {res_q[fhan_pkg::WIDE_W-2:0], fits};
					sh_q  <= sh_q >> 1;
				end
				fhan_pkg::ALU_SQRT: begin
					if (fits) begin
						acc_q <= sum[fhan_pkg::WIDE_W-1:0];
						res_q <= (res_q >> 1) | sh_q;
					end else begin
						res_q <= res_q >> 1;
					end
					sh_q <= sh_q >> 2;
				end
				default: begin
					sh_q <= sh_q;
				end
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == fhan_pkg::ALU_MUL) ? acc_q : res_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("operation started while the unit was busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("unit finished without flagging completion");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("completion flag held for more than one cycle");

endmodule

@@ src/fhan_seq.sv @@
`timescale 1ns / 1ps
// Sequencer and state of the tracking differentiator around the shared unit.
module fhan_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  cmd,
	input  logic [47:0]           value,
	input  logic                  out_free,
	input  fhan_pkg::cfg_t        cfg,
	input  fhan_pkg::alu_rsp_t    rsp,
	output fhan_pkg::alu_req_t    req,
	output fhan_pkg::seq_status_t status
);

	fhan_pkg::seq_state_t state_q, state_d;
	logic         issued_q;
	logic [47:0]  x1_q, x2_q, tgt_q, fh_q;
	logic [46:0]  d_q;
	logic [47:0]  nh_q;
	logic [54:0]  d0_q;
	logic [50:0]  y_q;
	logic [60:0]  mag_q;
	logic [93:0]  dd_q;
	logic [100:0] sq_q;
	logic [61:0]  a_q;
	logic [93:0]  prod_q;

	logic         issuing;
	logic [15:0]  n_eff;
	logic [47:0]  mh, x2_mag, fh_mag;
	logic [50:0]  y_new;
	logic [50:0]  y_neg;
	logic [49:0]  ym;
	logic         y_pos;
	logic         lin_short;
	logic [60:0]  lin_cap;
	logic [50:0]  a0_diff;
	logic [61:0]  x2s, a_new, am;
	logic         a_pos;
	logic [49:0]  nx2_raw, x1_raw;
	logic [47:0]  nx2_sat, nx2, x1_sat, lim48, lq48;

	function automatic logic [47:0] sat48(input logic [49:0] v);
		if (v[49:47] != {3{v[49]}}) begin
			return v[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		end
		return v[47:0];
	endfunction

	always_comb begin
		n_eff   = (cfg.n < fhan_pkg::FILTER_FACTOR_MIN) ? fhan_pkg::FILTER_FACTOR_MIN : cfg.n;
		mh      = rsp.res[79:32];
		x2_mag  = x2_q[47] ? (48'd0 - x2_q) : x2_q;
		fh_mag  = fh_q[47] ? (48'd0 - fh_q) : fh_q;
		y_new   = {{3{x1_q[47]}}, x1_q} - {{3{tgt_q[47]}}, tgt_q}
			+ (x2_q[47] ? (51'd0 - {3'b0, mh}) : {3'b0, mh});
		y_neg   = 51'd0 - y_q;
		ym      = y_q[50] ? y_neg[49:0] : y_q[49:0];
		y_pos   = !y_q[50] && (y_q != 51'd0);
		// A zero period or a quotient of at least twice the cap needs no division.
		lin_short = (cfg.h == 32'd0) || ({11'b0, ym} >= ({29'b0, cfg.h} << 29));
		lin_cap = (rsp.res[60:0] > fhan_pkg::LIN_CAP) ? fhan_pkg::LIN_CAP : rsp.res[60:0];
		a0_diff = rsp.res[50:0] - {4'b0, d_q};
		x2s     = {{14{x2_q[47]}}, x2_q};
		a_new   = y_pos ? (x2s + {1'b0, mag_q}) : (x2s - {1'b0, mag_q});
		am      = a_q[61] ? (62'd0 - a_q) : a_q;
		a_pos   = !a_q[61] && (a_q != 62'd0);
		lq48    = {1'b0, rsp.res[46:0]};
		nx2_raw = {{2{x2_q[47]}}, x2_q}
			+ (fh_q[47] ? (50'd0 - {2'b0, mh}) : {2'b0, mh});
		nx2_sat = sat48(nx2_raw);
		lim48   = {1'b0, cfg.lim};
		nx2     = nx2_sat;
		if (cfg.lim != 47'd0) begin
			if ($signed(nx2_sat) > $signed(lim48)) begin
				nx2 = lim48;
			end else if ($signed(nx2_sat) < $signed(48'd0 - lim48)) begin
				nx2 = 48'd0 - lim48;
			end
		end
		x1_raw  = {{2{x1_q[47]}}, x1_q}
			+ (x2_q[47] ? (50'd0 - {2'b0, mh}) : {2'b0, mh});
		x1_sat  = sat48(x1_raw);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fhan_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (cmd == fhan_pkg::CMD_LOAD) ? fhan_pkg::ST_DONE : fhan_pkg::ST_RH;
				end
			end
			fhan_pkg::ST_RH:  if (rsp.done) state_d = fhan_pkg::ST_NH;
			fhan_pkg::ST_NH:  if (rsp.done) state_d = fhan_pkg::ST_D0;
			fhan_pkg::ST_D0:  if (rsp.done) state_d = fhan_pkg::ST_HX2;
			fhan_pkg::ST_HX2: if (rsp.done) state_d = fhan_pkg::ST_BR;
			fhan_pkg::ST_BR: begin
				if ({5'b0, ym} <= d0_q) begin
					state_d = lin_short ? fhan_pkg::ST_A : fhan_pkg::ST_LIN;
				end else begin
					state_d = fhan_pkg::ST_DD;
				end
			end
			fhan_pkg::ST_LIN: if (rsp.done) state_d = fhan_pkg::ST_A;
			fhan_pkg::ST_DD:  if (rsp.done) state_d = fhan_pkg::ST_RY;
			fhan_pkg::ST_RY:  if (rsp.done) state_d = fhan_pkg::ST_SQ;
			fhan_pkg::ST_SQ:  if (rsp.done) state_d = fhan_pkg::ST_A;
			fhan_pkg::ST_A:   state_d = fhan_pkg::ST_FH;
			fhan_pkg::ST_FH: begin
				if (a_q != 62'd0 && am <= {15'b0, d_q}) begin
					state_d = fhan_pkg::ST_RAM;
				end else begin
					state_d = fhan_pkg::ST_HFH;
				end
			end
			fhan_pkg::ST_RAM: if (rsp.done) state_d = fhan_pkg::ST_LQ;
			fhan_pkg::ST_LQ:  if (rsp.done) state_d = fhan_pkg::ST_HFH;
			fhan_pkg::ST_HFH: if (rsp.done) state_d = fhan_pkg::ST_HX1;
			fhan_pkg::ST_HX1: if (rsp.done) state_d = fhan_pkg::ST_DONE;
			fhan_pkg::ST_DONE: if (out_free) state_d = fhan_pkg::ST_IDLE;
			default: state_d = fhan_pkg::ST_IDLE;
		endcase
	end

	// Requests to the shared unit.
	always_comb begin
		issuing   = 1'b1;
		req.op    = fhan_pkg::ALU_MUL;
		req.a     = '0;
		req.b     = '0;
		req.steps = 7'd32;
		case (state_q)
			fhan_pkg::ST_RH: begin
				req.a = {81'b0, cfg.r};
				req.b = {32'b0, cfg.h};
			end
			fhan_pkg::ST_NH: begin
				req.a     = {96'b0, cfg.h};
				req.b     = {48'b0, n_eff};
				req.steps = 7'd16;
			end
			fhan_pkg::ST_D0: begin
				req.a     = {80'b0, nh_q};
				req.b     = {17'b0, d_q};
				req.steps = 7'd47;
			end
			fhan_pkg::ST_HX2, fhan_pkg::ST_HX1: begin
				req.a = {80'b0, x2_mag};
				req.b = {32'b0, cfg.h};
			end
			fhan_pkg::ST_LIN: begin
				req.op    = fhan_pkg::ALU_DIV;
				req.a     = {46'b0, ym, 32'b0};
				req.b     = {32'b0, cfg.h};
				req.steps = 7'd61;
			end
			fhan_pkg::ST_DD: begin
				req.a     = {81'b0, d_q};
				req.b     = {17'b0, d_q};
				req.steps = 7'd47;
			end
			fhan_pkg::ST_RY: begin
				req.a     = {75'b0, ym, 3'b0};
				req.b     = {17'b0, cfg.r};
				req.steps = 7'd47;
			end
			fhan_pkg::ST_SQ: begin
				req.op    = fhan_pkg::ALU_SQRT;
				req.a     = {27'b0, sq_q};
				req.steps = 7'd51;
			end
			fhan_pkg::ST_RAM: begin
				req.a     = {81'b0, am[46:0]};
				req.b     = {17'b0, cfg.r};
				req.steps = 7'd47;
			end
			fhan_pkg::ST_LQ: begin
				req.op    = fhan_pkg::ALU_DIV;
				req.a     = {34'b0, prod_q};
				req.b     = {17'b0, d_q};
				req.steps = 7'd47;
			end
			fhan_pkg::ST_HFH: begin
				req.a = {80'b0, fh_mag};
				req.b = {32'b0, cfg.h};
			end
			default: issuing = 1'b0;
		endcase
		req.start = issuing && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fhan_pkg::ST_IDLE;
			issued_q <= 1'b0;
			x1_q     <= '0;
			x2_q     <= '0;
		end else begin
			state_q <= state_d;
			if (req.start) begin
				issued_q <= 1'b1;
			end else if (rsp.done) begin
				issued_q <= 1'b0;
			end
			if (state_q == fhan_pkg::ST_IDLE && start && cmd == fhan_pkg::CMD_LOAD) begin
				x1_q <= value;
				x2_q <= '0;
			end
			if (state_q == fhan_pkg::ST_HFH && rsp.done) begin
				x2_q <= nx2;
			end
			if (state_q == fhan_pkg::ST_HX1 && rsp.done) begin
				x1_q <= x1_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fhan_pkg::ST_IDLE: if (start) tgt_q <= value;
			fhan_pkg::ST_RH:   if (rsp.done) d_q <= rsp.res[78:32];
			fhan_pkg::ST_NH:   if (rsp.done) nh_q <= rsp.res[47:0];
			fhan_pkg::ST_D0:   if (rsp.done) d0_q <= rsp.res[94:40];
			fhan_pkg::ST_HX2:  if (rsp.done) y_q <= y_new;
			fhan_pkg::ST_BR: begin
				if (cfg.h == 32'd0) begin
					mag_q <= '0;
				end else begin
					mag_q <= fhan_pkg::LIN_CAP;
				end
			end
			fhan_pkg::ST_LIN:  if (rsp.done) mag_q <= lin_cap;
			fhan_pkg::ST_DD:   if (rsp.done) dd_q <= rsp.res[93:0];
			fhan_pkg::ST_RY:   if (rsp.done) sq_q <= {7'b0, dd_q} + rsp.res[100:0];
			fhan_pkg::ST_SQ:   if (rsp.done) mag_q <= {11'b0, a0_diff[50:1]};
			fhan_pkg::ST_A:    a_q <= a_new;
			fhan_pkg::ST_FH: begin
				if (a_q == 62'd0) begin
					fh_q <= '0;
				end else begin
					fh_q <= a_pos ? (48'd0 - {1'b0, cfg.r}) : {1'b0, cfg.r};
				end
			end
			fhan_pkg::ST_RAM:  if (rsp.done) prod_q <= rsp.res[93:0];
			fhan_pkg::ST_LQ:   if (rsp.done) fh_q <= a_pos ? (48'd0 - lq48) : lq48;
			default: begin
			end
		endcase
	end

	assign status.idle     = (state_q == fhan_pkg::ST_IDLE);
	assign status.valid    = (state_q == fhan_pkg::ST_DONE);
	assign status.position = x1_q;
	assign status.velocity = x2_q;

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> issued_q)
		else $error("unit completed without an outstanding request");
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fhan_pkg::ST_IDLE) |-> !issued_q)
		else $error("request left outstanding in idle");
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> !req.start)
		else $error("two requests issued back to back");

endmodule

@@ src/fhan_tracking_differentiator.sv @@
`timescale 1ns / 1ps
// Top level of the fixed-point Han tracking differentiator.
//
// Input transactions arrive on the s_axis channel: tuser carries the command
// (update toward the target, or load the position) and tdata the signed
// Q24.24 value. Every input transaction yields exactly one output transaction
// on m_axis carrying the new position and velocity.
// Configuration is written through cfg_valid, cfg_index and cfg_data, which
// is always ready; registers must only be changed while the block is idle.
// A load command needs no arithmetic and goes straight to the finished state.
// An update walks one bit-serial multiply, divide and square-root unit through
// the fhan steps, one bit per cycle. The linear branch adds a divide unless
// the period is zero or the quotient reaches twice the cap; the square-root
// branch adds two multiplies and a square root, and linear acceleration a
// multiply and a further divide.
// One transaction is handled at a time; s_axis_tready is high only while the
// sequencer is idle, from the cycle after the result enters the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register is free, and no new input is accepted meanwhile.
// Reset clears the state and the output valid flag and restores the defaults.
module fhan_tracking_differentiator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // [47:0] value
	input  logic        s_axis_tuser,  // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // [47:0] position, [95:48] velocity
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [46:0] cfg_data
);

	fhan_pkg::cfg_t        cfg_q;
	fhan_pkg::alu_req_t    req;
	fhan_pkg::alu_rsp_t    rsp;
	fhan_pkg::seq_status_t status;
	logic                  m_tvalid_q;
	logic [95:0]           m_tdata_q;
	logic                  out_free;
	logic                  in_accept;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = status.idle;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	// The output register can take a new result when it is empty or is
	// being emptied in this cycle.
	assign out_free      = !m_tvalid_q || m_axis_tready;

	// Configuration registers; the index covers the whole register list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.r   <= fhan_pkg::TRACK_SPEED_RST;
			cfg_q.h   <= fhan_pkg::STEP_PERIOD_RST;
			cfg_q.n   <= fhan_pkg::FILTER_FACTOR_RST;
			cfg_q.lim <= fhan_pkg::VELOCITY_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fhan_pkg::REG_TRACK_SPEED:    cfg_q.r   <= cfg_data;
				fhan_pkg::REG_STEP_PERIOD:    cfg_q.h   <= cfg_data[31:0];
				fhan_pkg::REG_FILTER_FACTOR:  cfg_q.n   <= cfg_data[15:0];
				fhan_pkg::REG_VELOCITY_LIMIT: cfg_q.lim <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Output register: takes a finished result from the sequencer once free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (status.valid && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (status.valid && out_free) begin
			m_tdata_q <= {status.velocity, status.position};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	fhan_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_accept),
		.cmd      (s_axis_tuser),
		.value    (s_axis_tdata),
		.out_free (out_free),
		.cfg      (cfg_q),
		.rsp      (rsp),
		.req      (req),
		.status   (status)
	);

	fhan_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the fixed-point Han tracking differentiator.
//
// The bench runs in the same order as the test tasks are called. The block
// is written several register settings, each one only while it is idle. A
// short directed part covers the extremes of the value field, both commands
// and the corner cases of fhan. These include a zero acceleration, a zero
// linear width, the raised filter factor, saturation of the state and the
// velocity clamp. Long random phases follow, and each one runs under its
// own setting. Most of their items are runs of updates toward a held target,
// so that the tracker really settles. The rest are loads and values drawn
// from the full range.
// Each accepted input transaction is run through a local predictor, and the
// expected position and velocity are queued. A separate process checks each
// output transaction against the oldest entry in that queue.
module tb_top;

	localparam int unsigned CYCLE_LIMIT = 5000000;
	localparam longint     POS_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint     POS_MIN     = -64'sh0000_8000_0000_0000;
	localparam logic [63:0] LIN_LIMIT  = 64'h1 << 60;

	typedef struct {
		logic [47:0] position;
		logic [47:0] velocity;
	} track_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = fhan_pkg::CMD_UPDATE;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = fhan_pkg::REG_TRACK_SPEED;
	logic [46:0] cfg_data = '0;

	// The bench's own copy of the registers and of the tracker state.
	logic [46:0] speed_r = fhan_pkg::TRACK_SPEED_RST;
	logic [31:0] period_h = fhan_pkg::STEP_PERIOD_RST;
	logic [15:0] factor_n = fhan_pkg::FILTER_FACTOR_RST;
	logic [46:0] vel_limit = fhan_pkg::VELOCITY_LIMIT_RST;
	longint      pos_est = 0;
	longint      vel_est = 0;

	track_state_t expected_states[$];
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;
	bit           calm = 1'b0;       // when set, neither side idles
	bit           stall_req = 1'b0;
	int unsigned  stall_left = 0;
	logic [47:0]  held_target = '0;

	fhan_tracking_differentiator u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),  // [47:0] value
		.s_axis_tuser (s_axis_tuser),  // [0] cmd
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),  // [47:0] position, [95:48] velocity
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// The long hold-off counts its own cycles. A request from the test
	// sequence loads the counter.
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left <= stall_left - 1;
		else if (stall_req)
			stall_left <= 400;
	end

	always @(posedge clk) begin
		if (stall_left != 0)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= calm || ($urandom_range(99) >= 24);
	end

	function automatic logic [63:0] magnitude(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	// Multiplies by the step period in Q0.32 and truncates towards zero.
	function automatic longint times_period(input longint v, input logic [63:0] h);
		logic [127:0] prod;
		longint       res;
		prod = {64'd0, magnitude(v)} * {64'd0, h};
		res = longint'(prod[95:32]);
		return v < 0 ? -res : res;
	endfunction

	function automatic longint clip48(input longint v);
		if (v > POS_MAX)
			return POS_MAX;
		if (v < POS_MIN)
			return POS_MIN;
		return v;
	endfunction

	// One tracker step. The new state is held in pos_est and vel_est.
	task automatic advance_tracker(input logic cmd, input logic [47:0] value);
		logic [63:0]  r, h, n, d, d0, ym, lin, a0, half, am, root, cand;
		logic [127:0] prod, quot, arg;
		longint       target, y, a, fh, nx2, lim;
		target = longint'(signed'(value));
		if (cmd == fhan_pkg::CMD_LOAD) begin
			pos_est = target;
			vel_est = 0;
			return;
		end
		r = 64'(speed_r);
		h = 64'(period_h);
		n = factor_n < fhan_pkg::FILTER_FACTOR_MIN ? 64'(fhan_pkg::FILTER_FACTOR_MIN)
			: 64'(factor_n);
		prod = {64'd0, r} * {64'd0, h};
		d = prod[95:32];
		prod = {64'd0, n * h} * {64'd0, d};
		d0 = prod[103:40];
		y = (pos_est - target) + times_period(vel_est, h);
		ym = magnitude(y);
		if (ym <= d0) begin
			// Linear region: the predicted error divided by the period, capped.
			if (h == 0) begin
				lin = 0;
			end else begin
				quot = {32'd0, ym, 32'd0} / {64'd0, h};
				lin = quot > {64'd0, LIN_LIMIT} ? LIN_LIMIT : quot[63:0];
			end
			a = y < 0 ? vel_est - longint'(lin) : vel_est + longint'(lin);
		end else begin
			arg = ({64'd0, d} * {64'd0, d}) + (({64'd0, r} * {64'd0, ym}) << 3);
			root = 0;
			for (int i = 63; i >= 0; i--) begin
				cand = root | (64'd1 << i);
				if (({64'd0, cand} * {64'd0, cand}) <= arg)
					root = cand;
			end
			a0 = root;
			half = (a0 - d) >> 1;
			a = y > 0 ? vel_est + longint'(half) : vel_est - longint'(half);
		end
		am = magnitude(a);
		if (am <= d) begin
			// Linear acceleration; a zero width leaves nothing to divide.
			if (d == 0)
				quot = 0;
			else
				quot = ({64'd0, r} * {64'd0, am}) / {64'd0, d};
			fh = a > 0 ? -longint'(quot[63:0]) : (a < 0 ? longint'(quot[63:0]) : 0);
		end else begin
			fh = a > 0 ? -longint'(r) : longint'(r);
		end
		nx2 = clip48(vel_est + times_period(fh, h));
		if (vel_limit != 0) begin
			lim = longint'(64'(vel_limit));
			if (nx2 > lim)
				nx2 = lim;
			else if (nx2 < -lim)
				nx2 = -lim;
		end
		vel_est = nx2;
		pos_est = clip48(pos_est + times_period(nx2, h));
	endtask

	task automatic report_mismatch(input string what, input logic [47:0] got,
			input logic [47:0] want);
		$display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want,
			cycle_count);
		fail_count++;
	endtask

	// Checks each output transaction against the oldest expected state.
	always @(posedge clk) begin
		track_state_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_states.size() == 0) begin
				report_mismatch("unexpected output", m_axis_tdata[47:0], '0);
			end else begin
				want = expected_states.pop_front();
				if (m_axis_tdata[47:0] !== want.position)
					report_mismatch("position", m_axis_tdata[47:0], want.position);
				if (m_axis_tdata[95:48] !== want.velocity)
					report_mismatch("velocity", m_axis_tdata[95:48], want.velocity);
			end
		end
	end

	// Offers one item, holds it until it is taken, then predicts its result.
	// The sender sometimes pauses first, and the item is never withdrawn.
	task automatic send_item(input logic cmd, input logic [47:0] value);
		track_state_t st;
		if (!calm && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= value;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		advance_tracker(cmd, value);
		st.position = pos_est[47:0];
		st.velocity = vel_est[47:0];
		expected_states.push_back(st);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Writes one register; the caller lowers cfg_valid after the last write.
	task automatic write_reg(input logic [1:0] idx, input logic [46:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			fhan_pkg::REG_TRACK_SPEED:    speed_r = data;
			fhan_pkg::REG_STEP_PERIOD:    period_h = data[31:0];
			fhan_pkg::REG_FILTER_FACTOR:  factor_n = data[15:0];
			fhan_pkg::REG_VELOCITY_LIMIT: vel_limit = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [46:0] r, input logic [31:0] h,
			input logic [15:0] n, input logic [46:0] lim);
		write_reg(fhan_pkg::REG_TRACK_SPEED, r);
		write_reg(fhan_pkg::REG_STEP_PERIOD, {15'd0, h});
		write_reg(fhan_pkg::REG_FILTER_FACTOR, {31'd0, n});
		write_reg(fhan_pkg::REG_VELOCITY_LIMIT, lim);
		cfg_valid <= 1'b0;
	endtask

	// A random value of a random bit length, so that small and large
	// magnitudes both turn up often.
	function automatic logic [63:0] scaled_random(input int unsigned max_bits);
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v >> (64 - $urandom_range(1, max_bits));
	endfunction

	task automatic test_reset;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
	endtask

	task automatic test_directed;
		// The register defaults: a load, a step towards 1.0 and the extremes.
		send_item(fhan_pkg::CMD_LOAD, 48'd0);
		send_item(fhan_pkg::CMD_UPDATE, 48'd0);               // zero acceleration
		send_item(fhan_pkg::CMD_UPDATE, 48'h0000_0100_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'h0000_0100_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'h7FFF_FFFF_FFFF);
		send_item(fhan_pkg::CMD_UPDATE, 48'h8000_0000_0000);
		send_item(fhan_pkg::CMD_LOAD, 48'h7FFF_FFFF_FFFF);
		send_item(fhan_pkg::CMD_UPDATE, 48'h8000_0000_0000);
		send_item(fhan_pkg::CMD_LOAD, 48'h8000_0000_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'h7FFF_FFFF_FFFF);
		drain();
		// Every register at its maximum: the state saturates quickly.
		set_config(47'h7FFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 47'h7FFF_FFFF_FFFF);
		send_item(fhan_pkg::CMD_LOAD, 48'h8000_0000_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'h7FFF_FFFF_FFFF);
		send_item(fhan_pkg::CMD_UPDATE, 48'h7FFF_FFFF_FFFF);
		send_item(fhan_pkg::CMD_UPDATE, 48'h8000_0000_0000);
		drain();
		// The smallest settings leave a zero linear width. The filter factor
		// lies below 1.0 and is raised to it.
		set_config(47'd1, 32'd1, 16'd0, 47'd1);
		send_item(fhan_pkg::CMD_LOAD, 48'h0000_0300_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'd0);
		send_item(fhan_pkg::CMD_UPDATE, 48'h8000_0000_0000);
		drain();
		// A tight velocity clamp while stepping towards a distant target.
		set_config(fhan_pkg::TRACK_SPEED_RST, 32'h0100_0000, 16'd512, 47'h0000_0080_0000);
		send_item(fhan_pkg::CMD_LOAD, 48'd0);
		send_item(fhan_pkg::CMD_UPDATE, 48'h0000_6400_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'h0000_6400_0000);
		send_item(fhan_pkg::CMD_UPDATE, 48'hFFFF_9C00_0000);
		drain();
	endtask

	// Random items, mostly runs of updates towards a held target.
	task automatic test_random(input int unsigned count);
		logic [47:0] value;
		logic        cmd;
		for (int unsigned i = 0; i < count; i++) begin
			cmd = fhan_pkg::CMD_UPDATE;
			case ($urandom_range(19))
				0, 1: begin
					cmd = fhan_pkg::CMD_LOAD;
					value = 48'(signed'($urandom));
				end
				2: value = 48'({$urandom, $urandom});
				3: value = $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
				4, 5: begin
					held_target = 48'(signed'($urandom)) >>> $urandom_range(0, 8);
					value = held_target;
				end
				default: value = held_target;
			endcase
			if (cmd == fhan_pkg::CMD_UPDATE && $urandom_range(29) == 0) begin
				cmd = fhan_pkg::CMD_LOAD;
				value = 48'({$urandom, $urandom});
			end
			send_item(cmd, value);
		end
		drain();
	endtask

	// Holds the receiver off for a long stretch while items keep coming, so
	// that the output fills up and the block stops accepting input.
	task automatic test_backpressure;
		stall_req <= 1'b1;
		@(posedge clk);
		stall_req <= 1'b0;
		for (int i = 0; i < 6; i++)
			send_item(i == 0 ? fhan_pkg::CMD_LOAD : fhan_pkg::CMD_UPDATE,
				48'h0000_0A00_0000 * i);
		drain();
	endtask

	task automatic test_random_configs;
		for (int p = 0; p < 4; p++) begin
			set_config(47'(scaled_random(36)) | 47'd1, 32'(scaled_random(32)) | 32'd1,
				16'(scaled_random(16)),
				$urandom_range(1) ? 47'd0 : 47'(scaled_random(40)));
			test_random(300);
		end
	endtask

	initial begin
		test_reset();
		test_directed();
		set_config(fhan_pkg::TRACK_SPEED_RST, fhan_pkg::STEP_PERIOD_RST,
			fhan_pkg::FILTER_FACTOR_RST, fhan_pkg::VELOCITY_LIMIT_RST);
		test_random(300);
		test_backpressure();
		// A long stretch with neither side idling.
		calm = 1'b1;
		set_config(47'h0000_2000_0000, 32'h0080_0000, 16'd1024, 47'd0);
		test_random(250);
		calm = 1'b0;
		test_random_configs();
		drain();
		repeat (30) @(posedge clk);
		if (fail_count == 0 && expected_states.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

@@ sim.f @@
src/fhan_pkg.sv
src/fhan_alu.sv
src/fhan_seq.sv
src/fhan_tracking_differentiator.sv
tb/tb_top.sv
